// ----- hdl/text_console_char_writer_macros.svh -----
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TCW_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error(MSG);

// Next-cycle implication, checked outside reset
`define TCW_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
    else $error(MSG);

`endif

// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int LINES    = 25;
  localparam int TAB_STEP = 8;
  localparam int CELLS    = LINES * COLUMNS;

  // Internal widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int LINE_W = $clog2(LINES);
  localparam int ADDR_W = $clog2(CELLS);

  // Transaction field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int CCOL_W = 7;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_LINE_W = 5;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] col;
  } tcw_in_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0]  cursor_col;
    logic [CUR_LINE_W-1:0] cursor_line;
    logic                  scrolled;
    logic [CHAR_W-1:0]     cell_char;
  } tcw_out_t;

  // Classified command kinds
  typedef enum logic [3:0] {
    K_PRINT,
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_TAB,
    K_IGNORE,
    K_READ,
    K_READ_OOR,
    K_CLEAR
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic [LINE_W-1:0] row;
    logic [COL_W-1:0]  col;
  } tcw_cmd_t;

  // Back end states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK
  } tcw_state_t;

  // What a blanking walk is for
  typedef enum logic [1:0] {
    WK_INIT,
    WK_CLEAR,
    WK_SCROLL
  } tcw_walk_t;

  // Screen row to store row through the ring offset
  function automatic logic [LINE_W-1:0] store_row(input logic [LINE_W-1:0] top,
                                                  input logic [LINE_W-1:0] srow);
    logic [LINE_W:0] sum;
    sum = {1'b0, top} + {1'b0, srow};
    if (sum >= (LINE_W+1)'(LINES)) begin
      sum = sum - (LINE_W+1)'(LINES);
    end
    return sum[LINE_W-1:0];
  endfunction

  // Linear store address of a store row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] srow,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(srow) * ADDR_W'(COLUMNS));
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tcw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/tcw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
  input  wire logic             start,
  input  wire tcw_pkg::tcw_in_t in_item,
  input  wire logic             q_full,
  input  wire logic             init_busy,
  output logic                  busy,
  output logic                  push,
  output tcw_pkg::tcw_cmd_t     push_cmd
);

  import tcw_pkg::*;

  // Hold off new transactions while the queue is full or the reset blanking pass runs
  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  // Classify the transaction into a back-end command
  always_comb begin
    push_cmd.kind = K_IGNORE;
    push_cmd.ch   = in_item.char_code;
    push_cmd.row  = LINE_W'(in_item.row);
    push_cmd.col  = COL_W'(in_item.col);
    case (in_item.op)
      OP_PUT: begin
        case (in_item.char_code)
          CH_NEWLINE:   push_cmd.kind = K_NEWLINE;
          CH_RETURN:    push_cmd.kind = K_RETURN;
          CH_BACKSPACE: push_cmd.kind = K_BACKSPACE;
          CH_TAB:       push_cmd.kind = K_TAB;
          default: begin
            if (in_item.char_code inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
              push_cmd.kind = K_PRINT;
            end
          end
        endcase
      end
      OP_READ: begin
        if (int'(in_item.row) < LINES && int'(in_item.col) < COLUMNS) begin
          push_cmd.kind = K_READ;
        end else begin
          push_cmd.kind = K_READ_OOR;
        end
      end
      OP_CLEAR: push_cmd.kind = K_CLEAR;
      default:  push_cmd.kind = K_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tcw_cmd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_cmd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tcw_pkg::tcw_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   valid,
  output tcw_pkg::tcw_cmd_t      head
);

  import tcw_pkg::*;

  tcw_cmd_t          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = q_mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- hdl/tcw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire tcw_pkg::tcw_cmd_t q_cmd,
  output logic                   pop,
  output logic                   init_busy,
  output logic                   out_valid,
  output tcw_pkg::tcw_out_t      out_item
);

  import tcw_pkg::*;

  tcw_state_t        state_r, state_nxt;
  tcw_walk_t         walk_kind_r, walk_kind_nxt;
  logic [ADDR_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [ADDR_W-1:0] walk_last_r, walk_last_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [LINE_W-1:0] cur_line_r, cur_line_nxt;
  logic [LINE_W-1:0] top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_item_r, out_item_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  logic [COL_W:0]    col_n;
  logic [LINE_W:0]   line_n;
  logic              direct;
  logic [LINE_W-1:0] cur_srow;

  // Cell store
  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  assign cur_srow = store_row(top_r, cur_line_r);
  assign raddr    = cell_addr(store_row(top_r, q_cmd.row), q_cmd.col);

  // State register and console state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WALK;
      walk_kind_r <= WK_INIT;
      walk_cnt_r  <= '0;
      walk_last_r <= ADDR_W'(CELLS - 1);
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_kind_r <= walk_kind_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      walk_last_r <= walk_last_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_line_r  <= cur_line_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // Next state, store access and result
  always_comb begin
    state_nxt     = state_r;
    walk_kind_nxt = walk_kind_r;
    walk_cnt_nxt  = walk_cnt_r;
    walk_last_nxt = walk_last_r;
    cur_col_nxt   = cur_col_r;
    cur_line_nxt  = cur_line_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = walk_cnt_r;
    wdata         = CH_BLANK;
    col_n         = {1'b0, cur_col_r};
    line_n        = {1'b0, cur_line_r};
    direct        = 1'b1;

    case (state_r)
      // Blank one cell per cycle: reset pass, clear or scrolled-out row
      ST_WALK: begin
        we           = 1'b1;
        walk_cnt_nxt = walk_cnt_r + 1'b1;
        if (walk_cnt_r == walk_last_r) begin
          state_nxt = ST_IDLE;
          out_item_nxt.cursor_col  = CUR_COL_W'(cur_col_r);
          out_item_nxt.cursor_line = CUR_LINE_W'(cur_line_r);
          out_item_nxt.cell_char   = '0;
          out_item_nxt.scrolled    = 1'b0;
          case (walk_kind_r)
            WK_SCROLL: begin
              top_nxt = (top_r == LINE_W'(LINES - 1)) ? '0 : top_r + 1'b1;
              out_item_nxt.scrolled = 1'b1;
              out_valid_nxt = 1'b1;
            end
            WK_CLEAR: out_valid_nxt = 1'b1;
            default:  out_valid_nxt = 1'b0;
          endcase
        end
      end

      // Read data is back from the store
      ST_READ: begin
        state_nxt                = ST_IDLE;
        out_valid_nxt            = 1'b1;
        out_item_nxt.cursor_col  = CUR_COL_W'(cur_col_r);
        out_item_nxt.cursor_line = CUR_LINE_W'(cur_line_r);
        out_item_nxt.scrolled    = 1'b0;
        out_item_nxt.cell_char   = rdata;
      end

      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_cmd.kind)
            K_PRINT: begin
              we    = 1'b1;
              waddr = cell_addr(cur_srow, cur_col_r);
              wdata = q_cmd.ch;
              col_n = col_n + 1'b1;
            end
            K_NEWLINE: begin
              col_n  = '0;
              line_n = line_n + 1'b1;
            end
            K_RETURN: col_n = '0;
            K_BACKSPACE: begin
              if (cur_col_r != '0) begin
                col_n = col_n - 1'b1;
                we    = 1'b1;
                waddr = cell_addr(cur_srow, cur_col_r - 1'b1);
                wdata = CH_BLANK;
              end
            end
            K_TAB: begin
              col_n = col_n + (COL_W+1)'(TAB_STEP) - (COL_W+1)'(cur_col_r % TAB_STEP);
            end
            K_READ: begin
              direct    = 1'b0;
              state_nxt = ST_READ;
            end
            K_CLEAR: begin
              direct        = 1'b0;
              state_nxt     = ST_WALK;
              walk_kind_nxt = WK_CLEAR;
              walk_cnt_nxt  = '0;
              walk_last_nxt = ADDR_W'(CELLS - 1);
              cur_col_nxt   = '0;
              cur_line_nxt  = '0;
              top_nxt       = '0;
            end
            default: direct = 1'b1;
          endcase

          if (direct) begin
            // Column wrap, then scroll when the cursor falls off the bottom
            if (col_n >= (COL_W+1)'(COLUMNS)) begin
              col_n  = '0;
              line_n = line_n + 1'b1;
            end
            if (line_n >= (LINE_W+1)'(LINES)) begin
              line_n        = (LINE_W+1)'(LINES - 1);
              state_nxt     = ST_WALK;
              walk_kind_nxt = WK_SCROLL;
              walk_cnt_nxt  = cell_addr(top_r, '0);
              walk_last_nxt = cell_addr(top_r, COL_W'(COLUMNS - 1));
            end else begin
              out_valid_nxt = 1'b1;
            end
            cur_col_nxt              = col_n[COL_W-1:0];
            cur_line_nxt             = line_n[LINE_W-1:0];
            out_item_nxt.cursor_col  = CUR_COL_W'(col_n[COL_W-1:0]);
            out_item_nxt.cursor_line = CUR_LINE_W'(line_n[LINE_W-1:0]);
            out_item_nxt.scrolled    = 1'b0;
            out_item_nxt.cell_char   = '0;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign init_busy = (state_r == ST_WALK) && (walk_kind_r == WK_INIT);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- hdl/text_console_char_writer.sv -----
// Accepted transactions pass the command queue and result register; a read also
// passes the store read register. A scroll blanks a row of COLUMNS cells and a
// clear all LINES*COLUMNS cells, one cell per cycle through the single store write
// port. Throughput: one transaction per cycle for non-scrolling puts; reads also
// pass ST_READ. Reset: synchronous; then a blanking pass keeps busy high.
// Results are a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire tcw_pkg::tcw_in_t in_item,
  output logic                  busy,
  output logic                  out_valid,
  output tcw_pkg::tcw_out_t     out_item
);

  import tcw_pkg::*;

`include "text_console_char_writer_macros.svh"

  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  logic     init_busy;
  tcw_cmd_t push_cmd;
  tcw_cmd_t q_head;

  // Accept and classify
  tcw_front u_front (
    .start     (start),
    .in_item   (in_item),
    .q_full    (q_full),
    .init_busy (init_busy),
    .busy      (busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decoupling queue
  tcw_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Execute against the cell store
  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Checks
  `TCW_ASSERT_IMP(a_cursor_range, clk, rst_n, out_valid, (int'(out_item.cursor_col) < COLUMNS) && (int'(out_item.cursor_line) < LINES), "cursor out of range")
  `TCW_ASSERT_IMP(a_scroll_bottom, clk, rst_n, out_valid && out_item.scrolled, (int'(out_item.cursor_line) == LINES - 1) && (out_item.cell_char == '0), "scroll result malformed")
  `TCW_ASSERT_IMP(a_init_quiet, clk, rst_n, init_busy, !out_valid && busy, "result during reset blanking")
  `TCW_ASSERT_NEXT(a_pop_result, clk, rst_n, pop && init_busy, 1'b0, "queue popped during reset blanking")

endmodule

`default_nettype wire
